// ----- hw/rtl/cfe_pkg.sv -----
// Shared constants, config register codes and pipeline control type for the
// cyclic-prefix CFO estimator. No dependencies.
package cfe_pkg;

	localparam int MAX_PREFIX       = 256;
	localparam int SAMPLE_BITS      = 16;
	localparam int ANGLE_ITERATIONS = 16;
	localparam int FFT_LIMIT        = 4096;
	localparam int SUM_BITS         = 40;

	localparam int PROD_BITS     = 2 * SAMPLE_BITS;
	localparam int ADDR_BITS     = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
	localparam int CP_BITS       = 9;
	localparam int NF_BITS       = 13;
	localparam int CFG_DATA_BITS = NF_BITS;
	localparam int IDX_BITS      = $clog2(MAX_PREFIX + FFT_LIMIT + 1);
	localparam int CMP_BITS      = IDX_BITS + 1;

	localparam logic [CP_BITS-1:0] CP_RESET = CP_BITS'(16);
	localparam logic [NF_BITS-1:0] NF_RESET = NF_BITS'(64);

	// CORDIC datapath
	localparam int XY_BITS       = SUM_BITS + 4;
	localparam int Z_BITS        = 34;
	localparam int FRAC_BITS     = 16;
	localparam int ITER_BITS     = $clog2(ANGLE_ITERATIONS);
	localparam int TURN_ENTRIES  = 24;
	localparam int TURN_IDX_BITS = $clog2(TURN_ENTRIES);
	localparam int COARSE_SHIFT  = 8;
	localparam int ROUND_SHIFT   = 17;

	localparam logic signed [XY_BITS-1:0] NORM_LIM   = XY_BITS'(1) << (SUM_BITS - 2);
	localparam logic signed [XY_BITS-1:0] COARSE_LIM =
		XY_BITS'(1) << (SUM_BITS - 2 - COARSE_SHIFT);
	localparam logic signed [Z_BITS-1:0] HALF_TURN  = Z_BITS'(64'sd2147483648);
	localparam logic signed [Z_BITS-1:0] ROUND_BIAS = Z_BITS'(1) << (ROUND_SHIFT - 1);
	localparam logic signed [Z_BITS-1:0] FRAC_MAX   = Z_BITS'(16384);
	localparam logic signed [Z_BITS-1:0] FRAC_MIN   = -Z_BITS'(16384);
	localparam logic signed [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(16384);

	// atan(2^-i)/(2*pi) in units of 2^-32 turn
	localparam logic signed [Z_BITS-1:0] TURN_TABLE [TURN_ENTRIES] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81
	};

	typedef enum logic [0:0] {
		CFG_CP_LENGTH = 1'b0,
		CFG_FFT_SIZE  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic real_hit;
		logic imag_hit;
		logic last;
	} tap_ctrl_t;

endpackage

// ----- hw/rtl/cfe_prefix_ram.sv -----
// Prefix sample store: one write port, two registered read ports.
// Depends on cfe_pkg.
module cfe_prefix_ram (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [cfe_pkg::ADDR_BITS-1:0]        wr_addr,
	input  logic signed [cfe_pkg::SAMPLE_BITS-1:0] wr_data,
	input  logic                                 rd_en,
	input  logic [cfe_pkg::ADDR_BITS-1:0]        rd_addr_a,
	input  logic [cfe_pkg::ADDR_BITS-1:0]        rd_addr_b,
	output logic signed [cfe_pkg::SAMPLE_BITS-1:0] rd_data_a,
	output logic signed [cfe_pkg::SAMPLE_BITS-1:0] rd_data_b
);

	logic signed [cfe_pkg::SAMPLE_BITS-1:0] mem [cfe_pkg::MAX_PREFIX];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ----- hw/rtl/cfe_correlator.sv -----
// Lag-N and lag-N+1 multiply-accumulate: product stage, then 40-bit sums.
// Depends on cfe_pkg.
module cfe_correlator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cfe_pkg::tap_ctrl_t                     ctrl_s1,
	input  logic signed [cfe_pkg::SAMPLE_BITS-1:0] sample_s1,
	input  logic signed [cfe_pkg::SAMPLE_BITS-1:0] partner_re,
	input  logic signed [cfe_pkg::SAMPLE_BITS-1:0] partner_im,
	output logic signed [cfe_pkg::SUM_BITS-1:0]    sum_real,
	output logic signed [cfe_pkg::SUM_BITS-1:0]    sum_imag,
	output logic                                   done
);

	cfe_pkg::tap_ctrl_t ctrl_s2;
	logic signed [cfe_pkg::PROD_BITS-1:0] prod_re_s2;
	logic signed [cfe_pkg::PROD_BITS-1:0] prod_im_s2;
	logic signed [cfe_pkg::SUM_BITS-1:0]  sum_re_q;
	logic signed [cfe_pkg::SUM_BITS-1:0]  sum_im_q;
	logic                                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid) begin
			prod_re_s2 <= partner_re * sample_s1;
			prod_im_s2 <= partner_im * sample_s1;
		end
	end

	// sums clear on the cycle after the last product lands, when the
	// angle unit latches them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_re_q <= '0;
			sum_im_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= ctrl_s2.valid && ctrl_s2.last;
			if (done_q) begin
				sum_re_q <= '0;
				sum_im_q <= '0;
			end else if (ctrl_s2.valid) begin
				if (ctrl_s2.real_hit) begin
					sum_re_q <= sum_re_q + cfe_pkg::SUM_BITS'(prod_re_s2);
				end
				if (ctrl_s2.imag_hit) begin
					sum_im_q <= sum_im_q + cfe_pkg::SUM_BITS'(prod_im_s2);
				end
			end
		end
	end

	assign sum_real = sum_re_q;
	assign sum_imag = sum_im_q;
	assign done     = done_q;

endmodule

// ----- hw/rtl/cfe_angle_cordic.sv -----
// Iterative vectoring CORDIC: half-turn fold, normalize, rotate, round to Q0.15.
// Depends on cfe_pkg (iteration count, turn table, widths).
module cfe_angle_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [cfe_pkg::SUM_BITS-1:0]  x_in,
	input  logic signed [cfe_pkg::SUM_BITS-1:0]  y_in,
	output logic                                 done,
	output logic signed [cfe_pkg::FRAC_BITS-1:0] angle
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_ROTATE,
		ST_ROUND
	} state_t;

	state_t state_q;
	logic signed [cfe_pkg::XY_BITS-1:0]   x_q, y_q;
	logic signed [cfe_pkg::Z_BITS-1:0]    z_q;
	logic [cfe_pkg::ITER_BITS-1:0]        iter_q;
	logic                                 done_q;
	logic signed [cfe_pkg::FRAC_BITS-1:0] angle_q;

	logic signed [cfe_pkg::XY_BITS-1:0] x_ext, y_ext, xs, ys;
	logic signed [cfe_pkg::Z_BITS-1:0]  turn, z_biased, z_round;
	logic coarse_ok, fine_ok;

	always_comb begin
		x_ext     = cfe_pkg::XY_BITS'(x_in);
		y_ext     = cfe_pkg::XY_BITS'(y_in);
		xs        = x_q >>> iter_q;
		ys        = y_q >>> iter_q;
		turn      = cfe_pkg::TURN_TABLE[cfe_pkg::TURN_IDX_BITS'(iter_q)];
		coarse_ok = (x_q < cfe_pkg::COARSE_LIM) && (x_q > -cfe_pkg::COARSE_LIM) &&
			(y_q < cfe_pkg::COARSE_LIM) && (y_q > -cfe_pkg::COARSE_LIM);
		fine_ok   = (x_q < cfe_pkg::NORM_LIM) && (x_q > -cfe_pkg::NORM_LIM) &&
			(y_q < cfe_pkg::NORM_LIM) && (y_q > -cfe_pkg::NORM_LIM);
		z_biased  = z_q + cfe_pkg::ROUND_BIAS;
		z_round   = z_biased >>> cfe_pkg::ROUND_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			iter_q  <= '0;
			done_q  <= 1'b0;
			angle_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (x_in == '0 && y_in == '0) begin
							angle_q <= '0;
							done_q  <= 1'b1;
						end else if (x_in < 0 && y_in == '0) begin
							angle_q <= cfe_pkg::FRAC_HALF;
							done_q  <= 1'b1;
						end else if (x_in < 0) begin
							// fold into the right half plane
							x_q     <= -x_ext;
							y_q     <= -y_ext;
							z_q     <= (y_in > 0) ? cfe_pkg::HALF_TURN : -cfe_pkg::HALF_TURN;
							state_q <= ST_NORM;
						end else begin
							x_q     <= x_ext;
							y_q     <= y_ext;
							z_q     <= '0;
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if (coarse_ok) begin
						x_q <= x_q <<< cfe_pkg::COARSE_SHIFT;
						y_q <= y_q <<< cfe_pkg::COARSE_SHIFT;
					end else if (fine_ok) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						iter_q  <= '0;
						state_q <= ST_ROTATE;
					end
				end
				ST_ROTATE: begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + turn;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - turn;
					end
					iter_q <= iter_q + 1'b1;
					if (iter_q == cfe_pkg::ITER_BITS'(cfe_pkg::ANGLE_ITERATIONS - 1)) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (z_round > cfe_pkg::FRAC_MAX) begin
						angle_q <= cfe_pkg::FRAC_BITS'(cfe_pkg::FRAC_MAX);
					end else if (z_round < cfe_pkg::FRAC_MIN) begin
						angle_q <= cfe_pkg::FRAC_BITS'(cfe_pkg::FRAC_MIN);
					end else begin
						angle_q <= cfe_pkg::FRAC_BITS'(z_round);
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

// ----- hw/rtl/cp_fractional_cfo_estimator_core.sv -----
// Top level of the cyclic-prefix fractional CFO estimator: config registers,
// sample index control, prefix RAM, correlator and angle CORDIC.
// Depends on cfe_pkg, cfe_prefix_ram, cfe_correlator, cfe_angle_cordic.
//
// Usage
//   sample channel (sample_valid/sample_ready/sample): one real Q1.15 sample
//   per beat. An internal index numbers the samples of one symbol from 0 to
//   cp_length + fft_size. The first cp_length samples go to the prefix RAM.
//   result channel (result_valid/result_ready): one beat per symbol with
//   cfo_fraction (Q0.15 turns per symbol) and the two raw correlation sums.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   index 0 writes cp_length, index 1 writes fft_size. Values apply from the
//   next accepted sample.
// Throughput and result path
//   Every sample but the last of a symbol is taken at one per cycle. After
//   the last one sample_ready drops until the result beat is taken. The
//   sums pass to the angle unit, which answers from idle when both sums are
//   zero or the angle is a half turn, otherwise after its normalize steps
//   (8 bits per step while the sums are small, then 1), the 16 iterations
//   of the shared CORDIC stage and a rounding step.
// Reset
//   arst_n clears the index, sums, pipeline and handshakes and loads
//   cp_length = 16, fft_size = 64. The prefix RAM is not cleared.
// Stall
//   A stalled result beat holds its payload; no new sample is taken meanwhile.
module cp_fractional_cfo_estimator_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// config
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [0:0]                               cfg_index,
	input  logic [cfe_pkg::CFG_DATA_BITS-1:0]        cfg_data,
	// samples
	input  logic                                     sample_valid,
	output logic                                     sample_ready,
	input  logic signed [cfe_pkg::SAMPLE_BITS-1:0]   sample,
	// results
	output logic                                     result_valid,
	input  logic                                     result_ready,
	output logic signed [cfe_pkg::FRAC_BITS-1:0]     cfo_fraction,
	output logic signed [cfe_pkg::SUM_BITS-1:0]      corr_real,
	output logic signed [cfe_pkg::SUM_BITS-1:0]      corr_imag
);

	// config registers
	logic [cfe_pkg::CP_BITS-1:0] cp_len_q;
	logic [cfe_pkg::NF_BITS-1:0] fft_size_q;

	// index control
	logic [cfe_pkg::IDX_BITS-1:0] idx_q;
	logic                         busy_q;
	logic [cfe_pkg::CP_BITS-1:0]  cp_eff;
	logic [cfe_pkg::NF_BITS-1:0]  nf_eff;
	logic [cfe_pkg::CMP_BITS-1:0] idx_w, cp_w, nf_w, real_off, imag_off;
	logic wr_hit, real_hit, imag_hit, last_hit, take;

	// stage 1 (RAM read in flight)
	cfe_pkg::tap_ctrl_t                     ctrl_s1;
	logic signed [cfe_pkg::SAMPLE_BITS-1:0] sample_s1;
	logic signed [cfe_pkg::SAMPLE_BITS-1:0] partner_re, partner_im;

	// correlator / cordic
	logic signed [cfe_pkg::SUM_BITS-1:0]  sum_real, sum_imag;
	logic                                 corr_done;
	logic                                 angle_done;
	logic signed [cfe_pkg::FRAC_BITS-1:0] angle;

	// result register
	logic                                 result_valid_q;
	logic signed [cfe_pkg::FRAC_BITS-1:0] cfo_fraction_q;
	logic signed [cfe_pkg::SUM_BITS-1:0]  corr_real_q, corr_imag_q;

	assign cfg_ready    = 1'b1;
	assign sample_ready = !busy_q;
	assign take         = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_len_q   <= cfe_pkg::CP_RESET;
			fft_size_q <= cfe_pkg::NF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfe_pkg::cfg_reg_t'(cfg_index))
				cfe_pkg::CFG_CP_LENGTH: cp_len_q   <= cfg_data[cfe_pkg::CP_BITS-1:0];
				cfe_pkg::CFG_FFT_SIZE:  fft_size_q <= cfg_data;
			endcase
		end
	end

	// clamp config to the supported ranges, then derive the tap decisions
	always_comb begin
		if (cp_len_q == '0) begin
			cp_eff = cfe_pkg::CP_BITS'(1);
		end else if (int'(cp_len_q) > cfe_pkg::MAX_PREFIX) begin
			cp_eff = cfe_pkg::CP_BITS'(cfe_pkg::MAX_PREFIX);
		end else begin
			cp_eff = cp_len_q;
		end
		if (fft_size_q == '0) begin
			nf_eff = cfe_pkg::NF_BITS'(1);
		end else if (int'(fft_size_q) > cfe_pkg::FFT_LIMIT) begin
			nf_eff = cfe_pkg::NF_BITS'(cfe_pkg::FFT_LIMIT);
		end else begin
			nf_eff = fft_size_q;
		end
		idx_w    = cfe_pkg::CMP_BITS'(idx_q);
		cp_w     = cfe_pkg::CMP_BITS'(cp_eff);
		nf_w     = cfe_pkg::CMP_BITS'(nf_eff);
		real_off = idx_w - nf_w;
		imag_off = idx_w - nf_w - 1'b1;
		wr_hit   = idx_w < cp_w;
		real_hit = (idx_w >= nf_w) && (real_off < cp_w);
		imag_hit = (idx_w >= nf_w + 1'b1) && (imag_off < cp_w);
		last_hit = idx_w >= cp_w + nf_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			busy_q  <= 1'b0;
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid    <= take;
			ctrl_s1.real_hit <= real_hit;
			ctrl_s1.imag_hit <= imag_hit;
			ctrl_s1.last     <= last_hit;
			if (take) begin
				idx_q <= last_hit ? '0 : idx_q + 1'b1;
			end
			// hold off samples from the last of a symbol until the result leaves
			if (take && last_hit) begin
				busy_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample;
		end
	end

	// write of sample j and reads of j-N, j-N-1 never share an address
	// (N >= 1), and a read always comes after the write of its sample
	cfe_prefix_ram u_ram (
		.clk       (clk),
		.wr_en     (take && wr_hit),
		.wr_addr   (idx_q[cfe_pkg::ADDR_BITS-1:0]),
		.wr_data   (sample),
		.rd_en     (take),
		.rd_addr_a (real_off[cfe_pkg::ADDR_BITS-1:0]),
		.rd_addr_b (imag_off[cfe_pkg::ADDR_BITS-1:0]),
		.rd_data_a (partner_re),
		.rd_data_b (partner_im)
	);

	cfe_correlator u_corr (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl_s1    (ctrl_s1),
		.sample_s1  (sample_s1),
		.partner_re (partner_re),
		.partner_im (partner_im),
		.sum_real   (sum_real),
		.sum_imag   (sum_imag),
		.done       (corr_done)
	);

	cfe_angle_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (corr_done),
		.x_in   (sum_real),
		.y_in   (sum_imag),
		.done   (angle_done),
		.angle  (angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (angle_done) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (corr_done) begin
			corr_real_q <= sum_real;
			corr_imag_q <= sum_imag;
		end
		if (angle_done) begin
			cfo_fraction_q <= angle;
		end
	end

	assign result_valid = result_valid_q;
	assign cfo_fraction = cfo_fraction_q;
	assign corr_real    = corr_real_q;
	assign corr_imag    = corr_imag_q;

	a_result_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> !sample_ready)
		else $error("sample accepted while a result is pending");

	a_last_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last_hit) |=> busy_q)
		else $error("input not held off after last sample of symbol");

	a_corr_done_in_symbol_end: assert property (@(posedge clk) disable iff (!arst_n)
		corr_done |-> (busy_q && !result_valid_q))
		else $error("correlation sums finished outside a symbol end");

	a_angle_done_in_symbol_end: assert property (@(posedge clk) disable iff (!arst_n)
		angle_done |-> (busy_q && !result_valid_q))
		else $error("angle finished with no symbol pending or result unsent");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(idx_q) <= cfe_pkg::MAX_PREFIX + cfe_pkg::FFT_LIMIT)
		else $error("sample index ran past the longest symbol");

endmodule
